/* hw/rtl/cff_pkg.sv */
package cff_pkg;

	localparam int VEC_W   = 32;
	localparam int PEN_W   = 31;
	localparam int COEF_W  = 16;
	localparam int PROD_W  = 64;
	localparam int TAN_W   = 49;
	localparam int MAG_W   = 48;
	localparam int POS_W   = 6;
	localparam int NORM_W  = 30;
	localparam int SQR_W   = 2 * NORM_W;
	localparam int RAD_W   = 62;
	localparam int LEN_W   = 31;
	localparam int QUO_W   = 31;
	localparam int THR_W   = PEN_W + COEF_W;
	localparam int JT_W    = 33;
	localparam int FMAG_W  = 35;
	localparam int FPROD_W = FMAG_W + QUO_W;
	localparam int FOUT_W  = FPROD_W - 30;
	localparam int ST_W    = 32;

	localparam int FRONT_STAGES = 9;
	localparam int SQ_STEPS     = 31;
	localparam int ST_STEPS     = 16;
	localparam int DIV_STEPS    = 31;
	localparam int BACK_STAGES  = 5;
	localparam int LAT          = FRONT_STAGES + SQ_STEPS + DIV_STEPS + BACK_STAGES;

	// fields that ride alongside the tangent through the long sqrt and divide pipes
	typedef struct packed {
		logic signed [VEC_W-1:0] vx;
		logic signed [VEC_W-1:0] vy;
		logic [PEN_W-1:0]        pen;
		logic [COEF_W-1:0]       dyn;
		logic                    negx;
		logic                    negy;
		logic                    zero;
	} side_t;

	// arithmetic shift right rounding toward zero, |v| < 2^63
	function automatic logic signed [PROD_W-1:0] shr_tz(input logic signed [PROD_W-1:0] v,
			input int unsigned k);
		logic [PROD_W-1:0] mag;
		logic [PROD_W-1:0] m;
		mag = v[PROD_W-1] ? PROD_W'(-v) : PROD_W'(v);
		m   = mag >> k;
		return v[PROD_W-1] ? $signed(PROD_W'(-m)) : $signed(m);
	endfunction

	// signed magnitude to saturated 32 bit word
	function automatic logic signed [VEC_W-1:0] sat_out(input logic neg,
			input logic [FOUT_W-1:0] mag);
		logic signed [VEC_W-1:0] r;
		if (mag == '0) begin
			r = '0;
		end else if (neg) begin
			if (mag >= FOUT_W'(64'h8000_0000)) r = {1'b1, {(VEC_W-1){1'b0}}};
			else r = $signed(VEC_W'(-mag));
		end else begin
			if (mag > FOUT_W'(64'h7FFF_FFFF)) r = {1'b0, {(VEC_W-1){1'b1}}};
			else r = $signed(VEC_W'(mag));
		end
		return r;
	endfunction

endpackage

/* hw/rtl/cff_if.sv */
interface cff_in_if
	import cff_pkg::*;
();
	logic                     valid;
	logic                     ready;
	logic signed [VEC_W-1:0]  normal_x;
	logic signed [VEC_W-1:0]  normal_y;
	logic [PEN_W-1:0]         penetration_depth;
	logic signed [VEC_W-1:0]  rel_vel_x;
	logic signed [VEC_W-1:0]  rel_vel_y;
	logic [COEF_W-1:0]        dyn_friction_a;
	logic [COEF_W-1:0]        dyn_friction_b;
	logic [COEF_W-1:0]        stat_friction_a;
	logic [COEF_W-1:0]        stat_friction_b;

	modport source(output valid, normal_x, normal_y, penetration_depth, rel_vel_x, rel_vel_y,
		dyn_friction_a, dyn_friction_b, stat_friction_a, stat_friction_b, input ready);
	modport sink(input valid, normal_x, normal_y, penetration_depth, rel_vel_x, rel_vel_y,
		dyn_friction_a, dyn_friction_b, stat_friction_a, stat_friction_b, output ready);
endinterface

interface cff_out_if
	import cff_pkg::*;
();
	logic                     valid;
	logic                     ready;
	logic signed [VEC_W-1:0]  force_x;
	logic signed [VEC_W-1:0]  force_y;
	logic                     is_sticking;

	modport source(output valid, force_x, force_y, is_sticking, input ready);
	modport sink(input valid, force_x, force_y, is_sticking, output ready);
endinterface

/* hw/rtl/contact_friction_force_top.sv */
// 2d contact friction force, static and dynamic regimes
// contact: one word per contact (normal, penetration, relative velocity,
//   dynamic and static coefficients of both bodies)
// friction: one word per contact (force_x, force_y, is_sticking)
// pipeline: 76 register stages, from contact to friction:
//   9 front stages (products, projection, tangent, normalisation),
//   31 stages of the bit-per-stage tangent length square root,
//   31 stages of the two bit-per-stage unit tangent dividers,
//   5 back stages (jt, regime choice, force product, saturation)
// throughput: one contact per cycle unless friction stalls the pipe; every stage holds one word
// the whole pipeline advances together; when friction holds ready low with
//   a word waiting, every stage holds and contact.ready drops in the same
//   cycle, so nothing is lost or repeated; bubbles stay in place
// contact.ready follows friction.ready combinationally
// reset: all stage valid bits clear, no word in flight; data is not reset
module contact_friction_force_top
	import cff_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	cff_in_if.sink    contact,
	cff_out_if.source friction
);

	logic           pipe_en;
	logic [LAT-1:0] valid_s;

	assign pipe_en       = !valid_s[LAT-1] || friction.ready;
	assign contact.ready = pipe_en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= '0;
		end else if (pipe_en) begin
			valid_s <= {valid_s[LAT-2:0], contact.valid};
		end
	end

	// stage 1: v.n products, coefficient prep
	logic signed [VEC_W-1:0]  vx_s1, vy_s1, nx_s1, ny_s1;
	logic [PEN_W-1:0]         pen_s1;
	logic [COEF_W-1:0]        dyn_s1;
	logic [ST_W-1:0]          sprod_s1;
	logic signed [PROD_W-1:0] px_s1, py_s1;

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			vx_s1    <= contact.rel_vel_x;
			vy_s1    <= contact.rel_vel_y;
			nx_s1    <= contact.normal_x;
			ny_s1    <= contact.normal_y;
			pen_s1   <= contact.penetration_depth;
			dyn_s1   <= (contact.dyn_friction_a < contact.dyn_friction_b) ?
				contact.dyn_friction_a : contact.dyn_friction_b;
			sprod_s1 <= ST_W'(contact.stat_friction_a) * ST_W'(contact.stat_friction_b);
			px_s1    <= PROD_W'(contact.rel_vel_x) * PROD_W'(contact.normal_x);
			py_s1    <= PROD_W'(contact.rel_vel_y) * PROD_W'(contact.normal_y);
		end
	end

	// stage 2: saturated dot product
	logic signed [VEC_W-1:0]  vx_s2, vy_s2, nx_s2, ny_s2, d_s2;
	logic [PEN_W-1:0]         pen_s2;
	logic [COEF_W-1:0]        dyn_s2;
	logic [ST_W-1:0]          sprod_s2;
	logic signed [PROD_W-1:0] dsum;
	logic signed [VEC_W-1:0]  d_sat;

	always_comb begin
		dsum = shr_tz(px_s1, 16) + shr_tz(py_s1, 16);
		if (dsum > PROD_W'(64'sh7FFF_FFFF)) d_sat = {1'b0, {(VEC_W-1){1'b1}}};
		else if (dsum < -PROD_W'(64'sh8000_0000)) d_sat = {1'b1, {(VEC_W-1){1'b0}}};
		else d_sat = VEC_W'(dsum);
	end

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			vx_s2    <= vx_s1;
			vy_s2    <= vy_s1;
			nx_s2    <= nx_s1;
			ny_s2    <= ny_s1;
			pen_s2   <= pen_s1;
			dyn_s2   <= dyn_s1;
			sprod_s2 <= sprod_s1;
			d_s2     <= d_sat;
		end
	end

	// stage 3: projection onto the normal
	logic signed [VEC_W-1:0]  vx_s3, vy_s3;
	logic [PEN_W-1:0]         pen_s3;
	logic [COEF_W-1:0]        dyn_s3;
	logic [ST_W-1:0]          sprod_s3;
	logic signed [PROD_W-1:0] qx_s3, qy_s3;

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			vx_s3    <= vx_s2;
			vy_s3    <= vy_s2;
			pen_s3   <= pen_s2;
			dyn_s3   <= dyn_s2;
			sprod_s3 <= sprod_s2;
			qx_s3    <= PROD_W'(d_s2) * PROD_W'(nx_s2);
			qy_s3    <= PROD_W'(d_s2) * PROD_W'(ny_s2);
		end
	end

	// stage 4: tangent, exact
	logic signed [VEC_W-1:0]  vx_s4, vy_s4;
	logic [PEN_W-1:0]         pen_s4;
	logic [COEF_W-1:0]        dyn_s4;
	logic [ST_W-1:0]          sprod_s4;
	logic signed [TAN_W-1:0]  tx_s4, ty_s4;

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			vx_s4    <= vx_s3;
			vy_s4    <= vy_s3;
			pen_s4   <= pen_s3;
			dyn_s4   <= dyn_s3;
			sprod_s4 <= sprod_s3;
			tx_s4    <= TAN_W'(vx_s3) - TAN_W'(shr_tz(qx_s3, 16));
			ty_s4    <= TAN_W'(vy_s3) - TAN_W'(shr_tz(qy_s3, 16));
		end
	end

	// stage 5: magnitudes and signs
	side_t            side_s5;
	logic [MAG_W-1:0] ax_s5, ay_s5, big_s5;
	logic [ST_W-1:0]  sprod_s5;
	logic [MAG_W-1:0] ax_c, ay_c;

	assign ax_c = tx_s4[TAN_W-1] ? MAG_W'(-tx_s4) : MAG_W'(tx_s4);
	assign ay_c = ty_s4[TAN_W-1] ? MAG_W'(-ty_s4) : MAG_W'(ty_s4);

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			side_s5.vx   <= vx_s4;
			side_s5.vy   <= vy_s4;
			side_s5.pen  <= pen_s4;
			side_s5.dyn  <= dyn_s4;
			side_s5.negx <= tx_s4[TAN_W-1];
			side_s5.negy <= ty_s4[TAN_W-1];
			side_s5.zero <= (tx_s4 == '0) && (ty_s4 == '0);
			sprod_s5     <= sprod_s4;
			ax_s5        <= ax_c;
			ay_s5        <= ay_c;
			big_s5       <= (ax_c > ay_c) ? ax_c : ay_c;
		end
	end

	// stage 6: leading one of the larger magnitude
	side_t            side_s6;
	logic [MAG_W-1:0] ax_s6, ay_s6;
	logic [ST_W-1:0]  sprod_s6;
	logic [POS_W-1:0] msb_s6;
	logic [POS_W-1:0] msb_c;

	always_comb begin
		msb_c = '0;
		for (int i = 0; i < MAG_W; i++) begin
			if (big_s5[i]) msb_c = POS_W'(i);
		end
	end

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			side_s6  <= side_s5;
			ax_s6    <= ax_s5;
			ay_s6    <= ay_s5;
			sprod_s6 <= sprod_s5;
			msb_s6   <= msb_c;
		end
	end

	// stage 7: scale so the larger magnitude has its top bit at 29
	localparam logic [POS_W-1:0] NORM_MSB = POS_W'(NORM_W - 1);

	side_t             side_s7;
	logic [NORM_W-1:0] nax_s7, nay_s7;
	logic [ST_W-1:0]   sprod_s7;

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			side_s7  <= side_s6;
			sprod_s7 <= sprod_s6;
			if (msb_s6 > NORM_MSB) begin
				nax_s7 <= NORM_W'(ax_s6 >> (msb_s6 - NORM_MSB));
				nay_s7 <= NORM_W'(ay_s6 >> (msb_s6 - NORM_MSB));
			end else begin
				nax_s7 <= NORM_W'(ax_s6 << (NORM_MSB - msb_s6));
				nay_s7 <= NORM_W'(ay_s6 << (NORM_MSB - msb_s6));
			end
		end
	end

	// stage 8: squares
	side_t             side_s8;
	logic [NORM_W-1:0] nax_s8, nay_s8;
	logic [ST_W-1:0]   sprod_s8;
	logic [SQR_W-1:0]  sqx_s8, sqy_s8;

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			side_s8  <= side_s7;
			nax_s8   <= nax_s7;
			nay_s8   <= nay_s7;
			sprod_s8 <= sprod_s7;
			sqx_s8   <= SQR_W'(nax_s7) * SQR_W'(nax_s7);
			sqy_s8   <= SQR_W'(nay_s7) * SQR_W'(nay_s7);
		end
	end

	// stage 9 is index 0 of the square root pipe
	logic [RAD_W-1:0]  sq_x_s    [SQ_STEPS+1];
	logic [RAD_W-1:0]  sq_r_s    [SQ_STEPS+1];
	logic [ST_W-1:0]   st_x_s    [SQ_STEPS+1];
	logic [ST_W-1:0]   st_r_s    [SQ_STEPS+1];
	side_t             sq_side_s [SQ_STEPS+1];
	logic [NORM_W-1:0] sq_nax_s  [SQ_STEPS+1];
	logic [NORM_W-1:0] sq_nay_s  [SQ_STEPS+1];

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			sq_x_s[0]    <= RAD_W'(sqx_s8) + RAD_W'(sqy_s8);
			sq_r_s[0]    <= '0;
			st_x_s[0]    <= sprod_s8;
			st_r_s[0]    <= '0;
			sq_side_s[0] <= side_s8;
			sq_nax_s[0]  <= nax_s8;
			sq_nay_s[0]  <= nay_s8;
		end
	end

	// one result bit per stage; the static coefficient root runs in the first stages
	for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
		localparam logic [RAD_W-1:0] SBIT = RAD_W'(1) << (2 * (SQ_STEPS - 1 - k));
		logic [RAD_W-1:0] trial;

		assign trial = sq_r_s[k] + SBIT;

		always_ff @(posedge clk) begin
			if (pipe_en) begin
				sq_side_s[k+1] <= sq_side_s[k];
				sq_nax_s[k+1]  <= sq_nax_s[k];
				sq_nay_s[k+1]  <= sq_nay_s[k];
				if (sq_x_s[k] >= trial) begin
					sq_x_s[k+1] <= sq_x_s[k] - trial;
					sq_r_s[k+1] <= (sq_r_s[k] >> 1) + SBIT;
				end else begin
					sq_x_s[k+1] <= sq_x_s[k];
					sq_r_s[k+1] <= sq_r_s[k] >> 1;
				end
			end
		end

		if (k < ST_STEPS) begin : g_stat
			localparam logic [ST_W-1:0] TBIT = ST_W'(1) << (2 * (ST_STEPS - 1 - k));
			logic [ST_W-1:0] st_trial;

			assign st_trial = st_r_s[k] + TBIT;

			always_ff @(posedge clk) begin
				if (pipe_en) begin
					if (st_x_s[k] >= st_trial) begin
						st_x_s[k+1] <= st_x_s[k] - st_trial;
						st_r_s[k+1] <= (st_r_s[k] >> 1) + TBIT;
					end else begin
						st_x_s[k+1] <= st_x_s[k];
						st_r_s[k+1] <= st_r_s[k] >> 1;
					end
				end
			end
		end else begin : g_hold
			always_ff @(posedge clk) begin
				if (pipe_en) begin
					st_x_s[k+1] <= st_x_s[k];
					st_r_s[k+1] <= st_r_s[k];
				end
			end
		end
	end

	logic [LEN_W-1:0] len_c;
	assign len_c = sq_r_s[SQ_STEPS][LEN_W-1:0];

	// unit tangent: two restoring dividers, one quotient bit per stage
	logic [RAD_W-1:0]  dv_rx_s   [DIV_STEPS];
	logic [RAD_W-1:0]  dv_ry_s   [DIV_STEPS];
	logic [QUO_W-1:0]  dv_qx_s   [DIV_STEPS];
	logic [QUO_W-1:0]  dv_qy_s   [DIV_STEPS];
	logic [LEN_W-1:0]  dv_len_s  [DIV_STEPS];
	logic [COEF_W-1:0] dv_stat_s [DIV_STEPS];
	side_t             dv_side_s [DIV_STEPS];

	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
		localparam int QB = DIV_STEPS - 1 - k;
		logic [RAD_W-1:0]  rx_in, ry_in, dsh;
		logic [QUO_W-1:0]  qx_in, qy_in;
		logic [LEN_W-1:0]  len_in;
		logic [COEF_W-1:0] stat_in;
		side_t             side_in;

		if (k == 0) begin : g_first
			assign rx_in   = RAD_W'(sq_nax_s[SQ_STEPS]) << NORM_W;
			assign ry_in   = RAD_W'(sq_nay_s[SQ_STEPS]) << NORM_W;
			assign qx_in   = '0;
			assign qy_in   = '0;
			assign len_in  = len_c;
			assign stat_in = st_r_s[SQ_STEPS][COEF_W-1:0];
			assign side_in = sq_side_s[SQ_STEPS];
		end else begin : g_next
			assign rx_in   = dv_rx_s[k-1];
			assign ry_in   = dv_ry_s[k-1];
			assign qx_in   = dv_qx_s[k-1];
			assign qy_in   = dv_qy_s[k-1];
			assign len_in  = dv_len_s[k-1];
			assign stat_in = dv_stat_s[k-1];
			assign side_in = dv_side_s[k-1];
		end

		assign dsh = RAD_W'(len_in) << QB;

		always_ff @(posedge clk) begin
			if (pipe_en) begin
				dv_len_s[k]  <= len_in;
				dv_stat_s[k] <= stat_in;
				dv_side_s[k] <= side_in;
				if (rx_in >= dsh) begin
					dv_rx_s[k] <= rx_in - dsh;
					dv_qx_s[k] <= qx_in | (QUO_W'(1) << QB);
				end else begin
					dv_rx_s[k] <= rx_in;
					dv_qx_s[k] <= qx_in;
				end
				if (ry_in >= dsh) begin
					dv_ry_s[k] <= ry_in - dsh;
					dv_qy_s[k] <= qy_in | (QUO_W'(1) << QB);
				end else begin
					dv_ry_s[k] <= ry_in;
					dv_qy_s[k] <= qy_in;
				end
			end
		end
	end

	logic [QUO_W-1:0] ux_c, uy_c;
	side_t            dside_c;
	assign ux_c    = dv_qx_s[DIV_STEPS-1];
	assign uy_c    = dv_qy_s[DIV_STEPS-1];
	assign dside_c = dv_side_s[DIV_STEPS-1];

	// back stage 1: v.u products, thresholds
	logic signed [PROD_W-1:0] mx_b1, my_b1;
	logic [THR_W-1:0]         thr_b1, pdm_b1;
	logic [QUO_W-1:0]         ux_b1, uy_b1;
	logic                     negx_b1, negy_b1, zero_b1;
	logic signed [VEC_W-1:0]  sux_c, suy_c;

	assign sux_c = dside_c.negx ? -$signed(VEC_W'(ux_c)) : $signed(VEC_W'(ux_c));
	assign suy_c = dside_c.negy ? -$signed(VEC_W'(uy_c)) : $signed(VEC_W'(uy_c));

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			mx_b1   <= PROD_W'(dside_c.vx) * PROD_W'(sux_c);
			my_b1   <= PROD_W'(dside_c.vy) * PROD_W'(suy_c);
			thr_b1  <= THR_W'(dside_c.pen) * THR_W'(dv_stat_s[DIV_STEPS-1]);
			pdm_b1  <= THR_W'(dside_c.pen) * THR_W'(dside_c.dyn);
			ux_b1   <= ux_c;
			uy_b1   <= uy_c;
			negx_b1 <= dside_c.negx;
			negy_b1 <= dside_c.negy;
			zero_b1 <= dside_c.zero;
		end
	end

	// back stage 2: jt
	logic [JT_W-1:0]          aj_b2;
	logic                     negj_b2;
	logic [THR_W-1:0]         thr_b2, pdm_b2;
	logic [QUO_W-1:0]         ux_b2, uy_b2;
	logic                     negx_b2, negy_b2, zero_b2;
	logic signed [PROD_W-1:0] jt_c;

	assign jt_c = shr_tz(-(mx_b1 + my_b1), 30);

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			aj_b2   <= jt_c[PROD_W-1] ? JT_W'(-jt_c) : JT_W'(jt_c);
			negj_b2 <= jt_c[PROD_W-1];
			thr_b2  <= thr_b1;
			pdm_b2  <= pdm_b1;
			ux_b2   <= ux_b1;
			uy_b2   <= uy_b1;
			negx_b2 <= negx_b1;
			negy_b2 <= negy_b1;
			zero_b2 <= zero_b1;
		end
	end

	// back stage 3: static or dynamic regime
	logic [FMAG_W-1:0] fm_b3;
	logic [QUO_W-1:0]  ux_b3, uy_b3;
	logic              sgx_b3, sgy_b3, stick_b3, zero_b3;
	logic              stick_c;

	assign stick_c = zero_b2 ? (thr_b2 != '0) : (THR_W'({aj_b2, 12'b0}) < thr_b2);

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			stick_b3 <= stick_c;
			fm_b3    <= stick_c ? FMAG_W'(aj_b2) : pdm_b2[THR_W-1:12];
			sgx_b3   <= stick_c ? (negx_b2 ^ negj_b2) : !negx_b2;
			sgy_b3   <= stick_c ? (negy_b2 ^ negj_b2) : !negy_b2;
			ux_b3    <= ux_b2;
			uy_b3    <= uy_b2;
			zero_b3  <= zero_b2;
		end
	end

	// back stage 4: force magnitudes
	logic [FOUT_W-1:0] fx_b4, fy_b4;
	logic              sgx_b4, sgy_b4, stick_b4, zero_b4;
	logic [FPROD_W-1:0] fpx_c, fpy_c;

	assign fpx_c = FPROD_W'(fm_b3) * FPROD_W'(ux_b3);
	assign fpy_c = FPROD_W'(fm_b3) * FPROD_W'(uy_b3);

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			fx_b4    <= fpx_c[FPROD_W-1:30];
			fy_b4    <= fpy_c[FPROD_W-1:30];
			sgx_b4   <= sgx_b3;
			sgy_b4   <= sgy_b3;
			stick_b4 <= stick_b3;
			zero_b4  <= zero_b3;
		end
	end

	// back stage 5: saturation, output word
	logic signed [VEC_W-1:0] force_x_b5, force_y_b5;
	logic                    stick_b5;

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			force_x_b5 <= zero_b4 ? '0 : sat_out(sgx_b4, fx_b4);
			force_y_b5 <= zero_b4 ? '0 : sat_out(sgy_b4, fy_b4);
			stick_b5   <= stick_b4;
		end
	end

	assign friction.valid       = valid_s[LAT-1];
	assign friction.force_x     = force_x_b5;
	assign friction.force_y     = force_y_b5;
	assign friction.is_sticking = stick_b5;

	localparam int V_NORM = 6;
	localparam int V_LEN  = FRONT_STAGES + SQ_STEPS - 1;
	localparam int V_DIV  = V_LEN + DIV_STEPS;

	// a stalled pipe keeps every word where it is
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!pipe_en |=> $stable(valid_s))
		else $error("pipeline moved while stalled");

	a_norm_top: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s[V_NORM] && !side_s7.zero |-> (nax_s7[NORM_W-1] || nay_s7[NORM_W-1]) &&
			!(nax_s7[NORM_W-1] && 1'b0))
		else $error("tangent not normalised");

	a_len_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s[V_LEN] && !sq_side_s[SQ_STEPS].zero |-> len_c[LEN_W-1:NORM_W-1] != '0)
		else $error("tangent length below range");

	a_unit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s[V_DIV] && !dside_c.zero |->
			ux_c <= (QUO_W'(1) << NORM_W) && uy_c <= (QUO_W'(1) << NORM_W))
		else $error("unit tangent component above one");

endmodule
